// ===== hw/rtl/tsam_pkg.sv =====
package tsam_pkg;

  localparam int WORD_W     = 16;
  localparam int SAMPLE_W   = 13;
  localparam int DROP_BITS  = WORD_W - SAMPLE_W;
  localparam int AVG_SHIFT  = 4;
  localparam int SUM_W      = SAMPLE_W + AVG_SHIFT;
  localparam int CNT_W      = AVG_SHIFT;
  localparam int PIX_W      = 9;
  localparam int PROD_W     = SAMPLE_W + PIX_W;
  localparam int DIV_STEPS  = PIX_W;
  localparam int DCNT_W     = $clog2(DIV_STEPS);
  localparam int OUT_W      = 48;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  localparam logic [CNT_W-1:0]  LAST_COUNT = CNT_W'((1 << AVG_SHIFT) - 1);
  localparam logic [PIX_W-1:0]  X_PIX_MAX  = PIX_W'(239);
  localparam logic [PIX_W-1:0]  Y_PIX_MAX  = PIX_W'(319);

  localparam logic [2:0] REG_X_CAL_LOW  = 3'd0;
  localparam logic [2:0] REG_X_CAL_HIGH = 3'd1;
  localparam logic [2:0] REG_Y_CAL_LOW  = 3'd2;
  localparam logic [2:0] REG_Y_CAL_HIGH = 3'd3;
  localparam logic [2:0] REG_LANDSCAPE  = 3'd4;

  typedef struct packed {
    logic [SAMPLE_W-1:0] x_cal_low;
    logic [SAMPLE_W-1:0] x_cal_high;
    logic [SAMPLE_W-1:0] y_cal_low;
    logic [SAMPLE_W-1:0] y_cal_high;
    logic                landscape_mode;
  } cfg_t;

  typedef struct packed {
    logic take;
    logic mul;
    logic axis_y;
    logic step;
    logic save_x;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic div_last;
    logic out_free;
  } stat_t;

endpackage

// ===== hw/rtl/tsam_regs.sv =====
module tsam_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tsam_pkg::ADDR_W-1:0] paddr,
  input  logic [tsam_pkg::DATA_W-1:0] pwdata,
  output logic [tsam_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output tsam_pkg::cfg_t             cfg
);
  import tsam_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_cal_low      <= '0;
      cfg.x_cal_high     <= SAMPLE_W'(4095);
      cfg.y_cal_low      <= '0;
      cfg.y_cal_high     <= SAMPLE_W'(4095);
      cfg.landscape_mode <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        REG_X_CAL_LOW:  cfg.x_cal_low      <= pwdata[SAMPLE_W-1:0];
        REG_X_CAL_HIGH: cfg.x_cal_high     <= pwdata[SAMPLE_W-1:0];
        REG_Y_CAL_LOW:  cfg.y_cal_low      <= pwdata[SAMPLE_W-1:0];
        REG_Y_CAL_HIGH: cfg.y_cal_high     <= pwdata[SAMPLE_W-1:0];
        REG_LANDSCAPE:  cfg.landscape_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_X_CAL_LOW:  prdata = DATA_W'(cfg.x_cal_low);
      REG_X_CAL_HIGH: prdata = DATA_W'(cfg.x_cal_high);
      REG_Y_CAL_LOW:  prdata = DATA_W'(cfg.y_cal_low);
      REG_Y_CAL_HIGH: prdata = DATA_W'(cfg.y_cal_high);
      REG_LANDSCAPE:  prdata = DATA_W'(cfg.landscape_mode);
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/tsam_ctrl.sv =====
module tsam_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            pen,
  output logic            in_ready,
  input  tsam_pkg::stat_t stat,
  output tsam_pkg::cmd_t  cmd
);
  import tsam_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MULX = 3'd1;
  localparam logic [2:0] S_DIVX = 3'd2;
  localparam logic [2:0] S_MULY = 3'd3;
  localparam logic [2:0] S_DIVY = 3'd4;
  localparam logic [2:0] S_SEND = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.take = in_valid;
        if (in_valid) begin
          if (!pen) state_next = S_SEND;
          else if (stat.last) state_next = S_MULX;
        end
      end
      S_MULX: begin
        cmd.mul    = 1'b1;
        state_next = S_DIVX;
      end
      S_DIVX: begin
        cmd.step = 1'b1;
        if (stat.div_last) state_next = S_MULY;
      end
      S_MULY: begin
        // X quotient is still in the divider: capture it as Y starts
        cmd.mul    = 1'b1;
        cmd.axis_y = 1'b1;
        cmd.save_x = 1'b1;
        state_next = S_DIVY;
      end
      S_DIVY: begin
        cmd.step = 1'b1;
        if (stat.div_last) state_next = S_SEND;
      end
      S_SEND: begin
        // hold until the output register is free
        cmd.load = stat.out_free;
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

// ===== hw/rtl/tsam_dp.sv =====
module tsam_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  tsam_pkg::cfg_t              cfg,
  input  tsam_pkg::cmd_t              cmd,
  output tsam_pkg::stat_t             stat,
  input  logic                        pen,
  input  logic [tsam_pkg::WORD_W-1:0] x_word,
  input  logic [tsam_pkg::WORD_W-1:0] y_word,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tsam_pkg::OUT_W-1:0]  out_data,
  output logic                        out_lifted
);
  import tsam_pkg::*;

  logic [SUM_W-1:0]    x_sum, y_sum;
  logic [SUM_W-1:0]    x_sum_add, y_sum_add;
  logic [CNT_W-1:0]    pair_count;
  logic [SAMPLE_W-1:0] ax, ay;
  logic                lifted;

  logic [PROD_W-1:0]   rem, dsh;
  logic [PIX_W-1:0]    quo;
  logic [DCNT_W-1:0]   dcnt;
  logic [PIX_W-1:0]    px_scaled;

  logic [SAMPLE_W-1:0] avg_sel, lo_sel, hi_sel, diff, den;
  logic [PIX_W-1:0]    top_sel;
  logic                ge;

  logic [SAMPLE_W-1:0] raw_x, raw_y;
  logic [PIX_W-1:0]    pixel_x, pixel_y;
  logic [SAMPLE_W-1:0] raw_x_next, raw_y_next;
  logic [PIX_W-1:0]    pixel_x_next, pixel_y_next;
  logic [PIX_W-1:0]    sx_now, sy_now, py_now;

  assign x_sum_add = x_sum + SUM_W'(x_word[WORD_W-1:DROP_BITS]);
  assign y_sum_add = y_sum + SUM_W'(y_word[WORD_W-1:DROP_BITS]);

  assign stat.last     = (pair_count == LAST_COUNT);
  assign stat.div_last = (dcnt == DCNT_W'(DIV_STEPS - 1));
  assign stat.out_free = !out_valid || out_ready;

  // accumulate pairs; a pen lift restarts the run
  always_ff @(posedge clk) begin
    if (rst) begin
      x_sum      <= '0;
      y_sum      <= '0;
      pair_count <= '0;
      lifted     <= 1'b0;
    end else if (cmd.take) begin
      lifted <= !pen;
      if (!pen || stat.last) begin
        x_sum      <= '0;
        y_sum      <= '0;
        pair_count <= '0;
      end else begin
        x_sum      <= x_sum_add;
        y_sum      <= y_sum_add;
        pair_count <= pair_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && pen && stat.last) begin
      ax <= x_sum_add[SUM_W-1:AVG_SHIFT];
      ay <= y_sum_add[SUM_W-1:AVG_SHIFT];
    end
  end

  always_comb begin
    avg_sel = cmd.axis_y ? ay : ax;
    lo_sel  = cmd.axis_y ? cfg.y_cal_low  : cfg.x_cal_low;
    hi_sel  = cmd.axis_y ? cfg.y_cal_high : cfg.x_cal_high;
    top_sel = cmd.axis_y ? Y_PIX_MAX : X_PIX_MAX;
    diff    = avg_sel - lo_sel;
    den     = hi_sel - lo_sel;
  end

  // restoring divider, one quotient bit per cycle; the quotient is below top
  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (cmd.mul) begin
      dcnt <= '0;
    end else if (cmd.step) begin
      dcnt <= dcnt + DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      rem <= PROD_W'(diff) * PROD_W'(top_sel);
      dsh <= PROD_W'({den, {(DIV_STEPS-1){1'b0}}});
      quo <= '0;
    end else if (cmd.step) begin
      if (ge) rem <= rem - dsh;
      dsh <= dsh >> 1;
      quo <= {quo[PIX_W-2:0], ge};
    end
  end

  function automatic logic [PIX_W-1:0] clamp_scale(
    input logic [SAMPLE_W-1:0] avg,
    input logic [SAMPLE_W-1:0] lo,
    input logic [SAMPLE_W-1:0] hi,
    input logic [PIX_W-1:0]    top,
    input logic [PIX_W-1:0]    q
  );
    if (avg <= lo)      return '0;
    else if (avg >= hi) return top;
    else                return q;
  endfunction

  assign sx_now = clamp_scale(ax, cfg.x_cal_low, cfg.x_cal_high, X_PIX_MAX, quo);
  assign sy_now = clamp_scale(ay, cfg.y_cal_low, cfg.y_cal_high, Y_PIX_MAX, quo);
  assign py_now = Y_PIX_MAX - sy_now;

  always_ff @(posedge clk) begin
    if (cmd.save_x) px_scaled <= sx_now;
  end

  always_comb begin
    raw_x_next   = '0;
    raw_y_next   = '0;
    pixel_x_next = '0;
    pixel_y_next = '0;
    if (!lifted && !(ax == '0 && ay == '0)) begin
      if (cfg.landscape_mode) begin
        raw_x_next   = ay;
        raw_y_next   = ax;
        pixel_x_next = py_now;
        pixel_y_next = X_PIX_MAX - px_scaled;
      end else begin
        raw_x_next   = ax;
        raw_y_next   = ay;
        pixel_x_next = px_scaled;
        pixel_y_next = py_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw_x      <= raw_x_next;
      raw_y      <= raw_y_next;
      pixel_x    <= pixel_x_next;
      pixel_y    <= pixel_y_next;
      out_lifted <= lifted;
    end
  end

  assign out_data = OUT_W'({pixel_y, pixel_x, raw_y, raw_x});

endmodule

// ===== hw/rtl/touch_sample_average_and_map.sv =====
// Touch sample averaging and pixel mapping.
// Input stream: one request per converter sample pair. s_tdata carries the X
// and Y words, s_tuser the pen-down flag. Each word's sample is word >> 3.
// Sixteen pen-down requests make one run; the last one yields a result with
// the averaged raw values and calibrated pixel coordinates. A pen-up request
// clears the run and yields an all-zero result with pen_lifted set.
// Output stream: m_tdata carries raw_x, raw_y, pixel_x, pixel_y; m_tuser is
// pen_lifted. Results sit in an output register until taken.
// Sequence: a request that ends no run is taken while the block stays idle.
// A pen-up request goes straight to the send step. The last request of a run
// goes through the multiply and the 9-step shared divider once per axis, then
// to the send step; s_tready is low meanwhile. A stalled receiver holds the
// block in its send step once a new result is ready; until then requests keep
// being taken. Reset (rst, synchronous) clears the run, empties the output
// register and loads the calibration registers with their defaults (limits 0
// and 4095, portrait). The user must write APB registers only while the block
// is idle; the block itself does not enforce it.
module touch_sample_average_and_map (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [31:0]                 s_tdata,   // x_word[15:0], y_word[31:16]
  input  logic                        s_tuser,   // pen_down
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // raw_x[12:0], raw_y[25:13], pixel_x[34:26], pixel_y[43:35], zero[47:44]
  output logic [tsam_pkg::OUT_W-1:0]  m_tdata,
  output logic                        m_tuser,   // pen_lifted
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tsam_pkg::ADDR_W-1:0] paddr,
  input  logic [tsam_pkg::DATA_W-1:0] pwdata,
  output logic [tsam_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import tsam_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  tsam_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tsam_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .pen      (s_tuser),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tsam_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .stat       (stat),
    .pen        (s_tuser),
    .x_word     (s_tdata[WORD_W-1:0]),
    .y_word     (s_tdata[2*WORD_W-1:WORD_W]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (m_tdata),
    .out_lifted (m_tuser)
  );

  a_lift_blocks_input : assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser |=> !s_tready)
    else $error("pen-up request did not start a result");

  a_lift_zero_data : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("pen-up result carries nonzero data");

  a_pixel_range : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[34:26] <= Y_PIX_MAX && m_tdata[43:35] <= Y_PIX_MAX)
    else $error("pixel coordinate out of range");

endmodule

// ===== verif/tb.sv =====
module tb;
  import tsam_pkg::*;

  localparam int PAIRS_PER_RUN = 1 << AVG_SHIFT;
  localparam int ITEM_TARGET = 1850;
  localparam int CALM_TAIL = 250;
  localparam int PHASE_ITEMS = 230;
  localparam int SETTLE_CYCLES = 30;
  localparam int QUIET_LIMIT = 2000;
  localparam int REPORT_LIMIT = 10;
  localparam logic [2:0] REG_UNMAPPED = 3'd5;
  localparam int X_TOP = 239;
  localparam int Y_TOP = 319;

  typedef struct packed {
    logic [SAMPLE_W-1:0] raw_x;
    logic [SAMPLE_W-1:0] raw_y;
    logic [PIX_W-1:0]    pixel_x;
    logic [PIX_W-1:0]    pixel_y;
    logic                pen_lifted;
  } touch_coord_t;

  typedef enum logic {ROW_PAIRS, ROW_WRITE} row_kind_t;
  typedef enum logic [1:0] {RUN_AIMED, RUN_NOISE, RUN_ZERO, RUN_LIFT} run_kind_t;

  typedef struct {
    row_kind_t    kind;
    int           count;
    logic         pen;
    logic [15:0]  x_word;
    logic [15:0]  y_word;
    logic         typed;
    touch_coord_t want;
    logic [2:0]   reg_idx;
    logic [31:0]  value;
  } stim_row_t;

  localparam touch_coord_t LIFTED = '{13'd0, 13'd0, 9'd0, 9'd0, 1'b1};

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [31:0]         s_tdata;
  logic                s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [OUT_W-1:0]    m_tdata;
  logic                m_tuser;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  touch_sample_average_and_map u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // shadow of the calibration registers and the averaging run
  cfg_t         cal = '{13'd0, 13'd4095, 13'd0, 13'd4095, 1'b0};
  int unsigned  x_acc = 0;
  int unsigned  y_acc = 0;
  int           pairs_in_run = 0;

  touch_coord_t pending_coords[$];
  int           coord_mismatches = 0;
  int           items_sent = 0;
  bit           idle_on = 1'b1;
  int           quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [PIX_W-1:0] scale_to_pixels(input logic [SAMPLE_W-1:0] avg,
                                                       input logic [SAMPLE_W-1:0] lo,
                                                       input logic [SAMPLE_W-1:0] hi,
                                                       input int unsigned top);
    int unsigned num;
    int unsigned span;
    if (avg <= lo) return '0;
    if (avg >= hi) return PIX_W'(top);
    num = (int'(avg) - int'(lo)) * top;
    span = int'(hi) - int'(lo);
    return PIX_W'(num / span);
  endfunction

  task automatic average_and_map(input logic pen, input logic [15:0] x_word,
                                 input logic [15:0] y_word, output bit produced,
                                 output touch_coord_t coord);
    logic [SAMPLE_W-1:0] ax;
    logic [SAMPLE_W-1:0] ay;
    logic [PIX_W-1:0]    px;
    logic [PIX_W-1:0]    py;
    produced = 1'b0;
    coord = '0;
    if (!pen) begin
      x_acc = 0;
      y_acc = 0;
      pairs_in_run = 0;
      coord = LIFTED;
      produced = 1'b1;
      return;
    end
    x_acc += x_word[15:3];
    y_acc += y_word[15:3];
    pairs_in_run++;
    if (pairs_in_run < PAIRS_PER_RUN) return;
    ax = SAMPLE_W'(x_acc >> AVG_SHIFT);
    ay = SAMPLE_W'(y_acc >> AVG_SHIFT);
    x_acc = 0;
    y_acc = 0;
    pairs_in_run = 0;
    produced = 1'b1;
    if (ax == 0 && ay == 0) return;
    px = scale_to_pixels(ax, cal.x_cal_low, cal.x_cal_high, X_TOP);
    py = PIX_W'(Y_TOP) - scale_to_pixels(ay, cal.y_cal_low, cal.y_cal_high, Y_TOP);
    if (cal.landscape_mode) begin
      coord = '{ay, ax, py, PIX_W'(X_TOP) - px, 1'b0};
    end else begin
      coord = '{ax, ay, px, py, 1'b0};
    end
  endtask

  // drive one request; on acceptance queue the typed or the predicted result
  task automatic send_pair(input logic pen, input logic [15:0] x_word,
                           input logic [15:0] y_word, input logic typed,
                           input touch_coord_t want);
    bit           produced;
    touch_coord_t coord;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {y_word, x_word};
    s_tuser <= pen;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    average_and_map(pen, x_word, y_word, produced, coord);
    if (produced) pending_coords.push_back(typed ? want : coord);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_X_CAL_LOW:  cal.x_cal_low = value[SAMPLE_W-1:0];
      REG_X_CAL_HIGH: cal.x_cal_high = value[SAMPLE_W-1:0];
      REG_Y_CAL_LOW:  cal.y_cal_low = value[SAMPLE_W-1:0];
      REG_Y_CAL_HIGH: cal.y_cal_high = value[SAMPLE_W-1:0];
      REG_LANDSCAPE:  cal.landscape_mode = value[0];
      default: ;
    endcase
  endtask

  // drop the request line, drain results, then let the block settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_coords.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // keep the calibration value, fill the unused upper bits with junk
  function automatic logic [31:0] with_junk(input logic [SAMPLE_W-1:0] field);
    logic [31:0] value;
    value = $urandom();
    value[SAMPLE_W-1:0] = field;
    return value;
  endfunction

  task automatic program_cal(input cfg_t c);
    logic [31:0] junk;
    junk = $urandom();
    write_reg(REG_X_CAL_LOW, with_junk(c.x_cal_low));
    write_reg(REG_X_CAL_HIGH, with_junk(c.x_cal_high));
    write_reg(REG_Y_CAL_LOW, with_junk(c.y_cal_low));
    write_reg(REG_Y_CAL_HIGH, with_junk(c.y_cal_high));
    write_reg(REG_LANDSCAPE, {junk[31:1], c.landscape_mode});
    if ($urandom_range(0, 2) == 0) write_reg(REG_UNMAPPED + 3'($urandom_range(0, 2)), $urandom());
  endtask

  function automatic int pick_center(input logic [SAMPLE_W-1:0] lo,
                                     input logic [SAMPLE_W-1:0] hi);
    int a;
    int b;
    a = (lo < hi) ? int'(lo) : int'(hi);
    b = (lo < hi) ? int'(hi) : int'(lo);
    a = (a < 64) ? 0 : a - 64;
    b = (b > 8191 - 64) ? 8191 : b + 64;
    return $urandom_range(b, a);
  endfunction

  function automatic logic [15:0] sample_word(input int center);
    int s;
    s = center + int'($urandom_range(0, 64)) - 32;
    if (s < 0) s = 0;
    if (s > 8191) s = 8191;
    return {SAMPLE_W'(s), 3'($urandom_range(0, 7))};
  endfunction

  task automatic send_run(input run_kind_t kind);
    int          abort_at;
    int          cx;
    int          cy;
    logic [15:0] x_word;
    logic [15:0] y_word;
    if (kind == RUN_LIFT) begin
      send_pair(1'b0, 16'($urandom()), 16'($urandom()), 1'b0, '0);
      return;
    end
    cx = pick_center(cal.x_cal_low, cal.x_cal_high);
    cy = pick_center(cal.y_cal_low, cal.y_cal_high);
    abort_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, PAIRS_PER_RUN - 1)
                                           : PAIRS_PER_RUN;
    for (int i = 0; i < PAIRS_PER_RUN; i++) begin
      if (i == abort_at) begin
        send_pair(1'b0, 16'($urandom()), 16'($urandom()), 1'b0, '0);
        break;
      end
      case (kind)
        RUN_NOISE: begin
          x_word = 16'($urandom());
          y_word = 16'($urandom());
        end
        RUN_ZERO: begin
          x_word = 16'($urandom_range(0, 7));
          y_word = 16'($urandom_range(0, 7));
        end
        default: begin
          x_word = sample_word(cx);
          y_word = sample_word(cy);
        end
      endcase
      send_pair(1'b1, x_word, y_word, 1'b0, '0);
    end
  endtask

  function automatic stim_row_t pair_row(input int count, input logic pen,
                                         input logic [15:0] x_word, input logic [15:0] y_word,
                                         input logic typed, input touch_coord_t want);
    stim_row_t row;
    row = '{ROW_PAIRS, count, pen, x_word, y_word, typed, want, 3'd0, 32'd0};
    return row;
  endfunction

  function automatic stim_row_t write_row(input logic [2:0] idx, input logic [31:0] value);
    stim_row_t row;
    row = '{ROW_WRITE, 0, 1'b0, 16'd0, 16'd0, 1'b0, '0, idx, value};
    return row;
  endfunction

  task automatic flag_coords(input string why, input touch_coord_t want,
                             input touch_coord_t got);
    coord_mismatches++;
    if (coord_mismatches <= REPORT_LIMIT)
      $display("%0t %s: want raw %0d/%0d pix %0d/%0d lift %0b, got raw %0d/%0d pix %0d/%0d lift %0b",
               $realtime, why, want.raw_x, want.raw_y, want.pixel_x, want.pixel_y,
               want.pen_lifted, got.raw_x, got.raw_y, got.pixel_x, got.pixel_y,
               got.pen_lifted);
  endtask

  always @(posedge clk) begin
    touch_coord_t got;
    touch_coord_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[12:0], m_tdata[25:13], m_tdata[34:26], m_tdata[43:35], m_tuser};
      if (pending_coords.size() == 0) begin
        flag_coords("unexpected result", '0, got);
      end else begin
        want = pending_coords.pop_front();
        if (got.raw_x !== want.raw_x || got.raw_y !== want.raw_y ||
            got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
            got.pen_lifted !== want.pen_lifted)
          flag_coords("result mismatch", want, got);
      end
    end
  end

  // receiver: random stall bursts while idling is allowed
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t directed[$];
    cfg_t      fixed_cal[4];
    cfg_t      next_cal;
    int        phase;
    int        phase_start;
    int        pick;

    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;

    fixed_cal[0] = '{13'd0, 13'd4095, 13'd0, 13'd4095, 1'b0};
    fixed_cal[1] = '{13'd0, 13'd8191, 13'd0, 13'd8191, 1'b1};
    fixed_cal[2] = '{13'd8191, 13'd8191, 13'd8191, 13'd8191, 1'b0};
    fixed_cal[3] = '{13'd0, 13'd0, 13'd8191, 13'd0, 1'b1};

    // pen up straight after reset, full-scale run, aborted run, zero average,
    // then landscape with an inverted X window and a stray register write
    directed.push_back(pair_row(1, 1'b0, 16'hFFFF, 16'hFFFF, 1'b1, LIFTED));
    directed.push_back(pair_row(16, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1,
                                '{13'd8191, 13'd8191, 9'd239, 9'd0, 1'b0}));
    directed.push_back(pair_row(3, 1'b1, 16'h8001, 16'h7FFE, 1'b0, '0));
    directed.push_back(pair_row(1, 1'b0, 16'h0000, 16'h0000, 1'b1, LIFTED));
    directed.push_back(pair_row(16, 1'b1, 16'h0007, 16'h0007, 1'b1, '0));
    directed.push_back(write_row(REG_UNMAPPED, 32'hFFFF_FFFF));
    directed.push_back(write_row(REG_X_CAL_LOW, 32'd3000));
    directed.push_back(write_row(REG_X_CAL_HIGH, 32'd1000));
    directed.push_back(write_row(REG_LANDSCAPE, 32'd1));
    directed.push_back(pair_row(16, 1'b1, 16'h4000, 16'h2000, 1'b0, '0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[r]) begin
      if (directed[r].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(directed[r].reg_idx, directed[r].value);
      end else begin
        for (int i = 0; i < directed[r].count; i++)
          send_pair(directed[r].pen, directed[r].x_word, directed[r].y_word,
                    directed[r].typed && i == directed[r].count - 1, directed[r].want);
      end
    end

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase < 4) begin
        next_cal = fixed_cal[phase];
      end else begin
        next_cal.x_cal_low = SAMPLE_W'($urandom_range(0, 4000));
        next_cal.x_cal_high = next_cal.x_cal_low + SAMPLE_W'($urandom_range(1, 4000));
        next_cal.y_cal_low = SAMPLE_W'($urandom_range(0, 4000));
        next_cal.y_cal_high = next_cal.y_cal_low + SAMPLE_W'($urandom_range(1, 4000));
        next_cal.landscape_mode = 1'($urandom());
        if ($urandom_range(0, 3) == 0) begin
          next_cal.x_cal_high = SAMPLE_W'($urandom());
          next_cal.y_cal_low = SAMPLE_W'($urandom());
        end
      end
      wait_idle();
      program_cal(next_cal);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS && items_sent < ITEM_TARGET) begin
        idle_on = (items_sent < ITEM_TARGET - CALM_TAIL);
        pick = $urandom_range(0, 19);
        if (pick == 0) send_run(RUN_LIFT);
        else if (pick == 1) send_run(RUN_ZERO);
        else if (pick <= 4) send_run(RUN_NOISE);
        else send_run(RUN_AIMED);
      end
      phase++;
    end
    s_tvalid <= 1'b0;

    while (pending_coords.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (coord_mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
